FILE: src/tcfo_pkg.sv
`timescale 1ns / 1ps

package tcfo_pkg;

    localparam int NAME_W  = 16;
    localparam int STAMP_W = 32;

    typedef enum logic [1:0] {
        ACT_ADD        = 2'd0,
        ACT_TAKE_CLASS = 2'd1,
        ACT_TAKE_ANY   = 2'd2,
        ACT_TAKE_ANY_X = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    localparam logic CLASS_DOG = 1'b0;
    localparam logic CLASS_CAT = 1'b1;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic [1:0]        action;
        logic              animal_class;
        logic [NAME_W-1:0] name_id;
    } request_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               taken_class;
        logic [NAME_W-1:0]  taken_name;
        logic [STAMP_W-1:0] taken_stamp;
    } result_t;

    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

endpackage

FILE: src/two_class_fifo_oldest_first.sv
`timescale 1ns / 1ps

// Two class queues (dog, cat) sharing one arrival-stamp counter. An add stores the
// name with the current stamp; a class take pops that class; a take-any pops the
// older head by wrap-aware stamp compare, cat on a tie. Each queue is a synchronous
// RAM with one read and one write port whose head entry is read at the accept edge
// and is ready in the following cycle, when the compare, pointer update and write back run:
// an item passes the accept and execute states in turn, and a new item is accepted
// only once the last has executed. Execution holds while the previous result is
// not taken. No clearing pass is needed after reset; queue contents are valid by
// count.
module two_class_fifo_oldest_first
    import tcfo_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int NAME_BITS   = 16,
    parameter int STAMP_BITS  = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  request_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output result_t  rsp
);

    localparam int NB = (NAME_BITS < NAME_W) ? NAME_BITS : NAME_W;

    state_t state_reg;
    state_t state_next;

    request_t req_reg;
    result_t  rsp_reg;
    result_t  res;
    logic     rsp_valid_reg;
    logic     rsp_valid_next;

    logic [STAMP_BITS-1:0] stamp_reg;
    logic [STAMP_BITS-1:0] stamp_next;
    logic [STAMP_BITS-1:0] stamp_diff;

    logic exec_fire;
    logic push_dog;
    logic push_cat;
    logic pop_dog;
    logic pop_cat;
    logic pick_dog;
    logic [NB-1:0] wr_name;

    logic [NB-1:0]         dog_head_name;
    logic [STAMP_BITS-1:0] dog_stamp;
    qstat_t                dog_stat;
    logic [NB-1:0]         cat_head_name;
    logic [STAMP_BITS-1:0] cat_stamp;
    qstat_t                cat_stat;

    tcfo_queue #(
        .DEPTH      (QUEUE_DEPTH),
        .NAME_BITS  (NB),
        .STAMP_BITS (STAMP_BITS)
    ) u_dog (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_dog),
        .pop        (pop_dog),
        .wr_name    (wr_name),
        .wr_stamp   (stamp_reg),
        .head_name  (dog_head_name),
        .head_stamp (dog_stamp),
        .stat       (dog_stat)
    );

    tcfo_queue #(
        .DEPTH      (QUEUE_DEPTH),
        .NAME_BITS  (NB),
        .STAMP_BITS (STAMP_BITS)
    ) u_cat (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_cat),
        .pop        (pop_cat),
        .wr_name    (wr_name),
        .wr_stamp   (stamp_reg),
        .head_name  (cat_head_name),
        .head_stamp (cat_stamp),
        .stat       (cat_stat)
    );

    assign wr_name    = req_reg.name_id[NB-1:0];
    assign stamp_diff = dog_stamp - cat_stamp;
    assign exec_fire  = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        res        = '0;
        push_dog   = 1'b0;
        push_cat   = 1'b0;
        pop_dog    = 1'b0;
        pop_cat    = 1'b0;
        pick_dog   = 1'b0;
        stamp_next = stamp_reg;
        case (req_reg.action)
            ACT_ADD:
            begin
                res.taken_class = req_reg.animal_class;
                if (req_reg.animal_class == CLASS_CAT ? cat_stat.full : dog_stat.full)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    res.status      = ST_OK;
                    res.taken_stamp = STAMP_W'(stamp_reg);
                    push_cat        = exec_fire && (req_reg.animal_class == CLASS_CAT);
                    push_dog        = exec_fire && (req_reg.animal_class == CLASS_DOG);
                    stamp_next      = exec_fire ? stamp_reg + 1'b1 : stamp_reg;
                end
            end
            ACT_TAKE_CLASS:
            begin
                res.taken_class = req_reg.animal_class;
                if (req_reg.animal_class == CLASS_CAT)
                begin
                    if (cat_stat.empty)
                    begin
                        res.status = ST_EMPTY;
                    end
                    else
                    begin
                        res.taken_name  = NAME_W'(cat_head_name);
                        res.taken_stamp = STAMP_W'(cat_stamp);
                        pop_cat         = exec_fire;
                    end
                end
                else
                begin
                    if (dog_stat.empty)
                    begin
                        res.status = ST_EMPTY;
                    end
                    else
                    begin
                        res.taken_name  = NAME_W'(dog_head_name);
                        res.taken_stamp = STAMP_W'(dog_stamp);
                        pop_dog         = exec_fire;
                    end
                end
            end
            default:
            begin
                if (dog_stat.empty && cat_stat.empty)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    if (cat_stat.empty)
                    begin
                        pick_dog = 1'b1;
                    end
                    else if (dog_stat.empty)
                    begin
                        pick_dog = 1'b0;
                    end
                    else
                    begin
                        pick_dog = stamp_diff[STAMP_BITS-1];
                    end
                    if (pick_dog)
                    begin
                        res.taken_class = CLASS_DOG;
                        res.taken_name  = NAME_W'(dog_head_name);
                        res.taken_stamp = STAMP_W'(dog_stamp);
                        pop_dog         = exec_fire;
                    end
                    else
                    begin
                        res.taken_class = CLASS_CAT;
                        res.taken_name  = NAME_W'(cat_head_name);
                        res.taken_stamp = STAMP_W'(cat_stamp);
                        pop_cat         = exec_fire;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        req_ready      = (state_reg == S_IDLE);
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            stamp_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            stamp_reg     <= stamp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
        if (exec_fire)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_rsp_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("result without execute cycle");

    a_stamp_on_add: assert property (@(posedge clk) disable iff (!rst_n)
        (push_dog || push_cat) |=> stamp_reg == $past(stamp_reg) + 1'b1)
        else $error("stamp did not advance on add");

    a_stamp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(push_dog || push_cat) |=> $stable(stamp_reg))
        else $error("stamp moved without add");

    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({push_dog, push_cat, pop_dog, pop_cat}) <= 1)
        else $error("more than one queue operation per item");

endmodule

FILE: src/tcfo_queue.sv
`timescale 1ns / 1ps

module tcfo_queue
    import tcfo_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int NAME_BITS  = 16,
    parameter int STAMP_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  pop,
    input  logic [NAME_BITS-1:0]  wr_name,
    input  logic [STAMP_BITS-1:0] wr_stamp,
    output logic [NAME_BITS-1:0]  head_name,
    output logic [STAMP_BITS-1:0] head_stamp,
    output qstat_t                stat
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ENTRY_W = NAME_BITS + STAMP_BITS;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_reg;

    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Read the head every cycle; a push is written before the next accept reads the head.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail_reg] <= {wr_name, wr_stamp};
        end
        rd_reg <= mem[head_reg];
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next  = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        else if (pop)
        begin
            head_next  = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign head_name  = rd_reg[ENTRY_W-1:STAMP_BITS];
    assign head_stamp = rd_reg[STAMP_BITS-1:0];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(DEPTH));

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

FILE: dv/tcfo_checker.sv
`timescale 1ns / 1ps

module tcfo_checker
    import tcfo_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_ready,
    input  request_t req,
    input  logic     rsp_valid,
    input  logic     rsp_ready,
    input  result_t  rsp,
    output int       fail_count,
    output int       pending
);

    localparam int DEPTH = 16;
    localparam int IDX_W = 4;

    logic [NAME_W-1:0]  name_mem  [2][DEPTH];
    logic [STAMP_W-1:0] stamp_mem [2][DEPTH];
    logic [IDX_W-1:0]   head_ptr  [2];
    logic [IDX_W-1:0]   tail_ptr  [2];
    logic [IDX_W:0]     fill      [2];
    logic [STAMP_W-1:0] stamp_next;

    result_t due_results [$];
    result_t want;

    task automatic report_error(string msg);
        $display("ERROR %0t: %s", $time, msg);
        fail_count++;
    endtask

    function automatic result_t pop_head(logic cls);
        result_t res;
        res             = '0;
        res.status      = ST_OK;
        res.taken_class = cls;
        res.taken_name  = name_mem[cls][head_ptr[cls]];
        res.taken_stamp = stamp_mem[cls][head_ptr[cls]];
        head_ptr[cls]   = head_ptr[cls] + 1'b1;
        fill[cls]       = fill[cls] - 1'b1;
        return res;
    endfunction

    function automatic result_t shelter_step(request_t r);
        result_t            res;
        logic               cls;
        logic               pick;
        logic [STAMP_W-1:0] gap;
        res = '0;
        cls = r.animal_class;
        if (r.action == ACT_ADD) begin
            res.taken_class = cls;
            if (fill[cls] == DEPTH) begin
                res.status = ST_FULL;
            end
            else begin
                name_mem[cls][tail_ptr[cls]]  = r.name_id;
                stamp_mem[cls][tail_ptr[cls]] = stamp_next;
                tail_ptr[cls]   = tail_ptr[cls] + 1'b1;
                fill[cls]       = fill[cls] + 1'b1;
                res.status      = ST_OK;
                res.taken_stamp = stamp_next;
                stamp_next      = stamp_next + 1'b1;
            end
        end
        else if (!r.action[1]) begin
            if (fill[cls] == 0) begin
                res.status      = ST_EMPTY;
                res.taken_class = cls;
            end
            else begin
                res = pop_head(cls);
            end
        end
        else begin
            if (fill[CLASS_DOG] == 0 && fill[CLASS_CAT] == 0) begin
                res.status      = ST_EMPTY;
                res.taken_class = CLASS_DOG;
            end
            else begin
                if (fill[CLASS_CAT] == 0) begin
                    pick = CLASS_DOG;
                end
                else if (fill[CLASS_DOG] == 0) begin
                    pick = CLASS_CAT;
                end
                else begin
                    gap  = stamp_mem[CLASS_DOG][head_ptr[CLASS_DOG]]
                         - stamp_mem[CLASS_CAT][head_ptr[CLASS_CAT]];
                    pick = gap[STAMP_W-1] ? CLASS_DOG : CLASS_CAT;
                end
                res = pop_head(pick);
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int c = 0; c < 2; c++) begin
                head_ptr[c] = '0;
                tail_ptr[c] = '0;
                fill[c]     = '0;
            end
            stamp_next = '0;
            due_results.delete();
            fail_count = 0;
            pending <= 0;
        end
        else begin
            if (rsp_valid && rsp_ready) begin
                if (due_results.size() == 0) begin
                    report_error($sformatf("unexpected result %h", rsp));
                end
                else begin
                    want = due_results.pop_front();
                    if (rsp.status !== want.status)
                        report_error($sformatf("status got %0h expected %0h",
                                               rsp.status, want.status));
                    if (rsp.taken_class !== want.taken_class)
                        report_error($sformatf("taken_class got %0h expected %0h",
                                               rsp.taken_class, want.taken_class));
                    if (rsp.taken_name !== want.taken_name)
                        report_error($sformatf("taken_name got %0h expected %0h",
                                               rsp.taken_name, want.taken_name));
                    if (rsp.taken_stamp !== want.taken_stamp)
                        report_error($sformatf("taken_stamp got %0h expected %0h",
                                               rsp.taken_stamp, want.taken_stamp));
                end
            end
            if (req_valid && req_ready) begin
                due_results.push_back(shelter_step(req));
            end
            pending <= due_results.size();
        end
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tcfo_pkg::*;

    localparam int ITEM_COUNT  = 400;
    localparam int PHASE_LEN   = 40;
    localparam int CALM_TAIL   = 60;
    localparam int PRESSURE_AT = 200;
    localparam int HOLD_CYCLES = 80;
    localparam int STALL_LIMIT = 2000;

    typedef enum int {
        MIX_EVEN,
        MIX_FILL,
        MIX_DRAIN
    } mix_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    request_t req       = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    result_t  rsp;
    logic     calm      = 1'b0;
    logic     hold_req  = 1'b0;
    int       fail_count;
    int       pending;
    int       idle_cycles = 0;

    two_class_fifo_oldest_first u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    tcfo_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk) begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        bit hold_served;
        hold_served = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_req && !hold_served) begin
                hold_served = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 4) == 0) begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(posedge clk);
            end
            else begin
                rsp_ready <= 1'b1;
                if (!calm) repeat ($urandom_range(0, 12)) @(posedge clk);
            end
        end
    end

    task automatic send_item(request_t item);
        if (!calm && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
    endtask

    function automatic request_t make_request(mix_t mix, logic favored);
        request_t r;
        int       roll;
        int       add_pct;
        r.name_id = NAME_W'($urandom());
        if ($urandom_range(0, 15) == 0) r.name_id = $urandom_range(0, 1) ? '1 : '0;
        r.animal_class = ($urandom_range(0, 99) < 75) ? favored : ~favored;
        case (mix)
            MIX_FILL:  add_pct = 85;
            MIX_DRAIN: add_pct = 15;
            default:   add_pct = 50;
        endcase
        roll = $urandom_range(0, 99);
        if (roll < add_pct) begin
            r.action = ACT_ADD;
        end
        else begin
            roll = $urandom_range(0, 9);
            if (roll < 5)      r.action = ACT_TAKE_CLASS;
            else if (roll < 9) r.action = ACT_TAKE_ANY;
            else               r.action = ACT_TAKE_ANY_X;
        end
        return r;
    endfunction

    initial begin
        mix_t mix;
        logic favored;
        mix     = MIX_EVEN;
        favored = CLASS_DOG;
        @(posedge rst_n);
        @(posedge clk);

        send_item('{ACT_TAKE_ANY,   CLASS_DOG, 16'h0000});
        send_item('{ACT_TAKE_CLASS, CLASS_DOG, 16'hFFFF});
        send_item('{ACT_TAKE_CLASS, CLASS_CAT, 16'h0000});
        send_item('{ACT_TAKE_ANY_X, CLASS_CAT, 16'hFFFF});
        send_item('{ACT_ADD,        CLASS_DOG, 16'h0000});
        send_item('{ACT_ADD,        CLASS_CAT, 16'hFFFF});
        send_item('{ACT_ADD,        CLASS_DOG, 16'hA5A5});
        send_item('{ACT_ADD,        CLASS_CAT, 16'h5A5A});
        send_item('{ACT_TAKE_ANY,   CLASS_CAT, 16'h1234});
        send_item('{ACT_TAKE_ANY_X, CLASS_DOG, 16'h0000});
        send_item('{ACT_TAKE_CLASS, CLASS_DOG, 16'h0000});
        send_item('{ACT_TAKE_ANY,   CLASS_DOG, 16'h0000});
        send_item('{ACT_ADD,        CLASS_DOG, 16'hFFFF});
        send_item('{ACT_TAKE_CLASS, CLASS_CAT, 16'h0000});
        send_item('{ACT_TAKE_ANY,   CLASS_CAT, 16'h0000});

        for (int n = 0; n < ITEM_COUNT; n++) begin
            if (n % PHASE_LEN == 0) begin
                mix     = mix_t'($urandom_range(0, 2));
                favored = 1'($urandom_range(0, 1));
            end
            if (n == ITEM_COUNT - CALM_TAIL) calm <= 1'b1;
            if (n == PRESSURE_AT) hold_req <= 1'b1;
            send_item(make_request(mix, favored));
        end
        req_valid <= 1'b0;

        @(posedge clk);
        wait (pending == 0);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
src/tcfo_pkg.sv
src/tcfo_queue.sv
src/two_class_fifo_oldest_first.sv
dv/tcfo_checker.sv
dv/testbench.sv
